>>> src/lfba_pkg.sv
// ----------------------------------------------------------------------------
// lfba_pkg: shared types and constants of the linked free-block allocator
// Payload structs, action codes, controller states and default sizing.
// ----------------------------------------------------------------------------
package lfba_pkg;

  // Width of every block number field on the ports
  localparam int FIELD_W = 10;

  // Default number of blocks in the link store
  localparam int NUM_BLOCKS_DEF = 1024;

  // Action codes carried in the input item
  typedef enum logic [2:0] {
    ACT_ALLOC      = 3'd0,
    ACT_SET_LINK   = 3'd1,
    ACT_READ_LINK  = 3'd2,
    ACT_FREE_CHAIN = 3'd3,
    ACT_FREE_ONE   = 3'd4
  } action_t;

  // Status codes carried in the result item
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CHAIN
  } state_t;

  // Input item
  typedef struct packed {
    logic [2:0]         action;
    logic [FIELD_W-1:0] block_index;
    logic [FIELD_W-1:0] link_value;
  } lfba_in_t;

  // Result item
  typedef struct packed {
    logic [FIELD_W-1:0] result_block;
    logic               status;
    logic [FIELD_W-1:0] free_blocks;
  } lfba_out_t;

endpackage

>>> src/linked_free_block_allocator_core.sv
// ----------------------------------------------------------------------------
// linked_free_block_allocator_core: free-list block allocator
// Keeps a singly linked free list threaded through a next-pointer memory.
// Supports allocate, set link, read link, free chain and free one block.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                     Handshake
//  --------  ------------------------  ---------------------------------------
//  input     start, busy, in_item      transfer when start && !busy
//  result    out_valid, out_item       one-cycle strobe, cannot be held off
//
//  Steps: allocate, set/read link, free one and unknown actions go from transfer
//  to result through a memory read and then an update step in ST_EXEC. Free
//  chain pushes the freed blocks one at a time, each step waiting on the memory
//  read of the next link. After reset the link memory is swept once with busy
//  high. A new item may be transferred in the cycle its predecessor's result is
//  strobed. Results are never stalled.
//
module linked_free_block_allocator_core
  import lfba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lfba_in_t  in_item,
  output logic      out_valid,
  output lfba_out_t out_item
);

  // Address, link and count widths
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int LW = (BW > FIELD_W) ? BW : FIELD_W;
  localparam int CW = BW;
  localparam int SW = BW + 1;

  localparam logic [LW:0]   NB_L     = (LW+1)'(NUM_BLOCKS);
  localparam logic [SW-1:0] NB_S     = SW'(NUM_BLOCKS);
  localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BLOCKS - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(NUM_BLOCKS - 1);

  // Controller and datapath registers
  state_t          state_r, state_nxt;
  logic [BW-1:0]   init_cnt_r, init_cnt_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [2:0]      act_r, act_nxt;
  logic [LW-1:0]   b_r, b_nxt;
  logic [LW-1:0]   lnk_r, lnk_nxt;
  logic [SW-1:0]   steps_r, steps_nxt;
  logic            out_valid_r, out_valid_nxt;
  lfba_out_t       out_r, out_nxt;

  // Link memory ports
  logic [LW-1:0]   mem [NUM_BLOCKS];
  logic            mem_we;
  logic [BW-1:0]   mem_wa;
  logic [LW-1:0]   mem_wd;
  logic [BW-1:0]   mem_ra;
  logic [LW-1:0]   rd_q_r;
  logic            fwd_hit_r;
  logic [LW-1:0]   fwd_data_r;
  logic [LW-1:0]   rd_data;

  logic [LW-1:0]   in_idx;
  logic            b_in_range;
  logic            head_in_range;
  logic            chain_go;
  logic [CW-1:0]   count_inc;

  assign in_idx        = LW'(in_item.block_index);
  assign b_in_range    = ({1'b0, b_r} < NB_L);
  assign head_in_range = ({1'b0, head_r} < NB_L);
  assign chain_go      = (b_r != '0) && b_in_range && (steps_r < NB_S);
  assign count_inc     = (count_r < CNT_MAX) ? count_r + CW'(1) : count_r;

  // Read data with forwarding of a same-cycle write to the same entry
  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

  // Link memory: one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r     <= mem[mem_ra];
    fwd_hit_r  <= mem_we && (mem_wa == mem_ra);
    fwd_data_r <= mem_wd;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (init_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_item.action == ACT_FREE_CHAIN) ? ST_CHAIN : ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_IDLE;
      ST_CHAIN: begin
        if (!chain_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    init_cnt_nxt  = init_cnt_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    act_nxt       = act_r;
    b_nxt         = b_r;
    lnk_nxt       = lnk_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_ra        = head_r[BW-1:0];

    unique case (state_r)
      // Sweep reset values into the link memory
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_wa       = init_cnt_r;
        mem_wd       = (init_cnt_r == LAST_IDX) ? '0 : LW'(init_cnt_r) + LW'(1);
        init_cnt_nxt = init_cnt_r + BW'(1);
      end

      // Capture the item and start the memory read it needs
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_item.action;
          b_nxt     = in_idx;
          lnk_nxt   = LW'(in_item.link_value);
          steps_nxt = '0;
          mem_ra    = (in_item.action == ACT_ALLOC) ? head_r[BW-1:0] : in_idx[BW-1:0];
        end
      end

      // Single-step actions; rd_data holds the link read at transfer
      ST_EXEC: begin
        out_valid_nxt        = 1'b1;
        out_nxt.result_block = '0;
        out_nxt.status       = STATUS_OK;
        unique case (act_r)
          ACT_ALLOC: begin
            if (count_r == '0) begin
              out_nxt.status = STATUS_EXHAUSTED;
            end else begin
              out_nxt.result_block = FIELD_W'(head_r);
              head_nxt  = head_in_range ? rd_data : '0;
              count_nxt = count_r - CW'(1);
            end
          end
          ACT_SET_LINK: begin
            if (b_in_range) begin
              mem_we = 1'b1;
              mem_wa = b_r[BW-1:0];
              mem_wd = lnk_r;
            end
          end
          ACT_READ_LINK: begin
            if (b_in_range) out_nxt.result_block = FIELD_W'(rd_data);
          end
          ACT_FREE_ONE: begin
            if ((b_r != '0) && b_in_range) begin
              mem_we    = 1'b1;
              mem_wa    = b_r[BW-1:0];
              mem_wd    = head_r;
              head_nxt  = b_r;
              count_nxt = count_inc;
            end
          end
          default: begin
          end
        endcase
        out_nxt.free_blocks = FIELD_W'(count_nxt);
      end

      // Chain walk: push current block, read next link in the same cycle; result at end
      ST_CHAIN: begin
        if (chain_go) begin
          mem_we    = 1'b1;
          mem_wa    = b_r[BW-1:0];
          mem_wd    = head_r;
          head_nxt  = b_r;
          count_nxt = count_inc;
          b_nxt     = rd_data;
          steps_nxt = steps_r + SW'(1);
          mem_ra    = rd_data[BW-1:0];
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.result_block = '0;
          out_nxt.status       = STATUS_OK;
          out_nxt.free_blocks  = FIELD_W'(count_r);
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      head_r      <= LW'(1);
      count_r     <= CNT_MAX;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    b_r   <= b_nxt;
    lnk_r <= lnk_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("free count above capacity");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wa <= LAST_IDX))
    else $error("link memory write outside the store");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= NB_S)
    else $error("chain walk ran past the block count");

  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == STATUS_EXHAUSTED)) |-> (count_r == '0))
    else $error("exhaustion reported with free blocks left");

endmodule
